// File: rtl/core/kclpd_pkg.sv
// Shared types and constants for the key click / long press detector.
// Holds the per-key record, the settings bundle, state and register codes.
// No dependencies.
package kclpd_pkg;

	localparam int KEY_W     = 3;
	localparam int CNT_W     = 16;
	localparam int CLICK_W   = 4;
	localparam int STATE_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 16;

	localparam logic [STATE_W-1:0] ST_RELEASED = 2'd0;
	localparam logic [STATE_W-1:0] ST_PRESSED  = 2'd1;
	localparam logic [STATE_W-1:0] ST_LONG     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CAP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLICKS    = 3'd6;

	typedef struct packed {
		logic [CNT_W-1:0]   press_count;
		logic [CNT_W-1:0]   release_count;
		logic [STATE_W-1:0] key_state;
		logic [CLICK_W-1:0] click_count;
		logic [CLICK_W-1:0] click_result;
	} key_rec_t;

	typedef struct packed {
		logic [CNT_W-1:0]   press_ticks;
		logic [CNT_W-1:0]   long_press_ticks;
		logic [CNT_W-1:0]   release_ticks;
		logic [CNT_W-1:0]   click_gap_ticks;
		logic [CNT_W-1:0]   press_count_cap;
		logic [CNT_W-1:0]   release_count_cap;
		logic [CLICK_W-1:0] max_clicks;
	} kclpd_cfg_t;

endpackage

// File: rtl/core/kclpd_cfg.sv
// Settings register bank of the key click / long press detector.
// Depends on kclpd_pkg.
module kclpd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kclpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kclpd_pkg::CNT_W-1:0]       cfg_data,
	output kclpd_pkg::kclpd_cfg_t             cfg
);

	kclpd_pkg::kclpd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks       <= 16'd10;
			cfg_q.long_press_ticks  <= 16'd500;
			cfg_q.release_ticks     <= 16'd10;
			cfg_q.click_gap_ticks   <= 16'd150;
			cfg_q.press_count_cap   <= 16'd1000;
			cfg_q.release_count_cap <= 16'd1000;
			cfg_q.max_clicks        <= 4'd7;
		end else if (cfg_valid) begin
			case (cfg_index)
				kclpd_pkg::REG_PRESS_TICKS:   cfg_q.press_ticks       <= cfg_data;
				kclpd_pkg::REG_LONG_TICKS:    cfg_q.long_press_ticks  <= cfg_data;
				kclpd_pkg::REG_RELEASE_TICKS: cfg_q.release_ticks     <= cfg_data;
				kclpd_pkg::REG_GAP_TICKS:     cfg_q.click_gap_ticks   <= cfg_data;
				kclpd_pkg::REG_PRESS_CAP:     cfg_q.press_count_cap   <= cfg_data;
				kclpd_pkg::REG_RELEASE_CAP:   cfg_q.release_count_cap <= cfg_data;
				kclpd_pkg::REG_MAX_CLICKS:
					cfg_q.max_clicks <= cfg_data[kclpd_pkg::CLICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/core/kclpd_update.sv
// Next-record logic for one scan tick of one key.
// Counters, debounce state and click sequencing. Depends on kclpd_pkg.
module kclpd_update (
	input  kclpd_pkg::key_rec_t   rec,
	input  logic                  pressed,
	input  kclpd_pkg::kclpd_cfg_t cfg,
	output kclpd_pkg::key_rec_t   rec_nxt
);

	always_comb begin
		logic [kclpd_pkg::CNT_W-1:0]   pc;
		logic [kclpd_pkg::CNT_W-1:0]   rc;
		logic [kclpd_pkg::STATE_W-1:0] st;
		logic [kclpd_pkg::CLICK_W-1:0] cc;
		logic [kclpd_pkg::CLICK_W-1:0] cr;

		pc = rec.press_count;
		rc = rec.release_count;
		st = rec.key_state;
		cc = rec.click_count;
		cr = rec.click_result;

		// advance the counter of the sampled level, hold at the cap
		if (pressed) begin
			if (pc < cfg.press_count_cap)
				pc = pc + 16'd1;
		end else begin
			if (rc < cfg.release_count_cap)
				rc = rc + 16'd1;
		end

		if (pc >= cfg.long_press_ticks) begin
			if (st == kclpd_pkg::ST_PRESSED) begin
				st = kclpd_pkg::ST_LONG;
				cc = '0;
				cr = '0;
				rc = '0;
			end
		end else if (pc >= cfg.press_ticks) begin
			if (st == kclpd_pkg::ST_RELEASED) begin
				st = kclpd_pkg::ST_PRESSED;
				if (cc < cfg.max_clicks)
					cc = cc + 4'd1;
				rc = '0;
			end
		end

		if (rc >= cfg.click_gap_ticks) begin
			if (cc != '0) begin
				cr = cc;
				cc = '0;
			end
		end else if (rc >= cfg.release_ticks) begin
			if (st != kclpd_pkg::ST_RELEASED) begin
				st = kclpd_pkg::ST_RELEASED;
				pc = '0;
			end
		end

		rec_nxt.press_count   = pc;
		rec_nxt.release_count = rc;
		rec_nxt.key_state     = st;
		rec_nxt.click_count   = cc;
		rec_nxt.click_result  = cr;
	end

endmodule

// File: rtl/core/key_click_long_press_detector.sv
// Key click / long press detector, top level.
// Input then output register; one request per cycle unless m_axis_tready stalls.
// Key records are read and updated combinationally from the input register, written back on advance.
// Reset clears all key records, settings return to defaults, both stages empty.
// Depends on kclpd_pkg, kclpd_cfg and kclpd_update.
module key_click_long_press_detector #(
	parameter int NUM_KEYS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [kclpd_pkg::S_DATA_W-1:0]      s_axis_tdata,  // key_index[2:0], pressed[3]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [kclpd_pkg::M_DATA_W-1:0]      m_axis_tdata,  // key_number[2:0], key_state[4:3],
	                                                           // running_clicks[8:5],
	                                                           // finished_clicks[12:9]
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kclpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kclpd_pkg::CNT_W-1:0]         cfg_data
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kclpd_pkg::kclpd_cfg_t cfg;

	logic                         valid_s1;
	logic [kclpd_pkg::KEY_W-1:0]  key_s1;
	logic                         pressed_s1;

	logic                         out_valid_q;
	logic [kclpd_pkg::M_DATA_W-1:0] out_data_q;
	logic [kclpd_pkg::M_DATA_W-1:0] out_data_nxt;

	kclpd_pkg::key_rec_t          recs_q [NUM_KEYS];
	kclpd_pkg::key_rec_t          rec_rd;
	kclpd_pkg::key_rec_t          rec_nxt;

	logic [6:0]                   key_ext;
	logic [IDX_W-1:0]             idx;
	logic                         in_range;
	logic                         advance;

	kclpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign key_ext  = {4'd0, key_s1};
	assign idx      = key_ext[IDX_W-1:0];
	assign in_range = (key_ext < 7'(NUM_KEYS));
	assign rec_rd   = in_range ? recs_q[idx] : '0;

	kclpd_update u_update (
		.rec     (rec_rd),
		.pressed (pressed_s1),
		.cfg     (cfg),
		.rec_nxt (rec_nxt)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign out_data_nxt = in_range ?
		{3'd0, rec_nxt.click_result, rec_nxt.click_count, rec_nxt.key_state, key_s1} :
		{13'd0, key_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			key_s1     <= s_axis_tdata[kclpd_pkg::KEY_W-1:0];
			pressed_s1 <= s_axis_tdata[kclpd_pkg::KEY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++)
				recs_q[k] <= '0;
		end else if (advance && in_range) begin
			recs_q[idx] <= rec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_data_nxt;
		end
	end

endmodule
